### hw/rtl/lcfe_pkg.sv
`default_nettype none
package lcfe_pkg;

   localparam int NUM_LEDS = 256;
   localparam int IDX_W    = $clog2(NUM_LEDS);
   localparam int CNT_W    = IDX_W + 1;
   localparam int COLOR_W  = 8;
   localparam int TIME_W   = 16;
   localparam int PROD_W   = COLOR_W + TIME_W;
   localparam int DSOR_W   = TIME_W + COLOR_W - 1;
   localparam int STEP_W   = $clog2(COLOR_W + 1);

   localparam logic [1:0] OP_DRIVE = 2'd0;
   localparam logic [1:0] OP_STEP  = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;
   localparam logic [1:0] OP_NOP   = 2'd3;

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [IDX_W-1:0]   led_index;
      logic [COLOR_W-1:0] target_red;
      logic [COLOR_W-1:0] target_green;
      logic [COLOR_W-1:0] target_blue;
      logic [TIME_W-1:0]  fade_duration_ms;
      logic [TIME_W-1:0]  step_ms;
   } lcfe_req_type;

   typedef struct packed {
      logic [COLOR_W-1:0] color_red;
      logic [COLOR_W-1:0] color_green;
      logic [COLOR_W-1:0] color_blue;
      logic               fade_running;
   } lcfe_rsp_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } lcfe_rgb_type;

   typedef struct packed {
      lcfe_rgb_type      start_color;
      lcfe_rgb_type      target_color;
      lcfe_rgb_type      current_color;
      logic [TIME_W-1:0] elapsed_time;
      logic [TIME_W-1:0] duration_time;
      logic              fade_active;
   } lcfe_slot_type;

   function automatic logic [COLOR_W-1:0] chan_sel(input lcfe_rgb_type rgb,
                                                   input logic [1:0] ch);
      logic [COLOR_W-1:0] lvl;
      unique case (ch)
         CH_RED:   lvl = rgb.red;
         CH_GREEN: lvl = rgb.green;
         default:  lvl = rgb.blue;
      endcase
      return lvl;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/lcfe_slot_ram.sv
`default_nettype none
module lcfe_slot_ram (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [lcfe_pkg::IDX_W-1:0]    wr_addr,
   input  lcfe_pkg::lcfe_slot_type       wr_data,
   input  logic [lcfe_pkg::IDX_W-1:0]    rd_addr,
   output lcfe_pkg::lcfe_slot_type       rd_data
);
   import lcfe_pkg::*;

   lcfe_slot_type        slot_mem_ff [NUM_LEDS];
   lcfe_slot_type        rd_q_ff;
   logic                 rd_vld_ff;
   logic [NUM_LEDS-1:0]  valid_ff;
   logic [NUM_LEDS-1:0]  valid_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
      rd_q_ff <= slot_mem_ff[rd_addr];
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         rd_vld_ff <= valid_ff[rd_addr];
      end
   end

   // never-written slots read as zero
   assign rd_data = rd_vld_ff ? rd_q_ff : '0;

endmodule
`default_nettype wire

### hw/rtl/lcfe_blend_unit.sv
`default_nettype none
module lcfe_blend_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [lcfe_pkg::COLOR_W-1:0]  from_level,
   input  logic [lcfe_pkg::COLOR_W-1:0]  to_level,
   input  logic [lcfe_pkg::TIME_W-1:0]   elapsed,
   input  logic [lcfe_pkg::TIME_W-1:0]   duration,
   output logic                          done,
   output logic [lcfe_pkg::COLOR_W-1:0]  level
);
   import lcfe_pkg::*;

   logic [PROD_W-1:0]  rem_ff,   rem_in;
   logic [DSOR_W-1:0]  dsor_ff,  dsor_in;
   logic [COLOR_W-1:0] quo_ff,   quo_in;
   logic [COLOR_W-1:0] base_ff,  base_in;
   logic               neg_ff,   neg_in;
   logic [STEP_W-1:0]  steps_ff, steps_in;

   logic [COLOR_W:0]   diff;
   logic [COLOR_W:0]   mag_w;
   logic               fits;
   logic [COLOR_W+1:0] sum;

   // quotient fits in COLOR_W bits since elapsed <= duration
   always_comb begin
      diff     = {1'b0, to_level} - {1'b0, from_level};
      mag_w    = diff[COLOR_W] ? (~diff + (COLOR_W+1)'(1)) : diff;
      fits     = rem_ff >= {1'b0, dsor_ff};
      rem_in   = rem_ff;
      dsor_in  = dsor_ff;
      quo_in   = quo_ff;
      base_in  = base_ff;
      neg_in   = neg_ff;
      steps_in = steps_ff;
      if (load) begin
         rem_in   = PROD_W'(mag_w[COLOR_W-1:0]) * PROD_W'(elapsed);
         dsor_in  = {duration, {(COLOR_W-1){1'b0}}};
         quo_in   = '0;
         base_in  = from_level;
         neg_in   = diff[COLOR_W];
         steps_in = STEP_W'(COLOR_W);
      end else if (steps_ff != '0) begin
         if (fits) begin
            rem_in = rem_ff - {1'b0, dsor_ff};
         end
         quo_in   = {quo_ff[COLOR_W-2:0], fits};
         dsor_in  = dsor_ff >> 1;
         steps_in = steps_ff - STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsor_ff <= dsor_in;
      quo_ff  <= quo_in;
      base_ff <= base_in;
      neg_ff  <= neg_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= '0;
      end else begin
         steps_ff <= steps_in;
      end
   end

   always_comb begin
      sum = neg_ff ? ({2'b00, base_ff} - {2'b00, quo_ff})
                   : ({2'b00, base_ff} + {2'b00, quo_ff});
      if (sum[COLOR_W+1]) begin
         level = '0;
      end else if (sum[COLOR_W]) begin
         level = '1;
      end else begin
         level = sum[COLOR_W-1:0];
      end
   end

   assign done = (steps_ff == '0);

endmodule
`default_nettype wire

### hw/rtl/led_color_fade_engine_unit.sv
`default_nettype none
// Drive: slot read, then written in ST_DRV_RD; busy while in that state.
// Query: rsp_strobe registered from ST_QRY_RD (from idle if index out of range).
// Step: per slot ST_STP_ISSUE and ST_STP_RD; a fading slot then runs 3 channels
//   through one shared multiply/8-step divide unit, then is written in ST_STP_WR.
// One request at a time; the result strobe cannot be stalled.
// Reset: synchronous; all slots read as zero, slot count 256, no clearing pass.
module led_color_fade_engine_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  lcfe_pkg::lcfe_req_type       req_data,
   output logic                         rsp_strobe,
   output lcfe_pkg::lcfe_rsp_type       rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [lcfe_pkg::CNT_W-1:0]   csr_data
);
   import lcfe_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE      = 8'b0000_0001,
      ST_DRV_RD    = 8'b0000_0010,
      ST_QRY_RD    = 8'b0000_0100,
      ST_STP_ISSUE = 8'b0000_1000,
      ST_STP_RD    = 8'b0001_0000,
      ST_STP_MUL   = 8'b0010_0000,
      ST_STP_DIV   = 8'b0100_0000,
      ST_STP_WR    = 8'b1000_0000
   } state_type;

   state_type          state_ff,      state_in;
   lcfe_req_type       cmd_ff,        cmd_in;
   logic [IDX_W-1:0]   slot_ff,       slot_in;
   lcfe_slot_type      ent_ff,        ent_in;
   logic [TIME_W-1:0]  next_ff,       next_in;
   logic [1:0]         chan_ff,       chan_in;
   lcfe_rgb_type       res_ff,        res_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   lcfe_rsp_type       rsp_data_ff,   rsp_data_in;
   logic [CNT_W-1:0]   count_ff,      count_in;

   logic [CNT_W-1:0]   slots;
   logic [CNT_W-1:0]   slot_nxt;
   logic [TIME_W:0]    time_sum;
   logic               wr_en;
   lcfe_slot_type      wr_data;
   logic [IDX_W-1:0]   rd_addr;
   lcfe_slot_type      rd_data;
   lcfe_rgb_type       req_rgb;
   logic               div_load;
   logic               div_done;
   logic [COLOR_W-1:0] div_level;

   lcfe_slot_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lcfe_blend_unit u_blend (
      .clock      (clock),
      .reset      (reset),
      .load       (div_load),
      .from_level (chan_sel(ent_ff.start_color, chan_ff)),
      .to_level   (chan_sel(ent_ff.target_color, chan_ff)),
      .elapsed    (next_ff),
      .duration   (ent_ff.duration_time),
      .done       (div_done),
      .level      (div_level)
   );

   assign slots     = (count_ff > CNT_W'(NUM_LEDS)) ? CNT_W'(NUM_LEDS) : count_ff;
   assign slot_nxt  = {1'b0, slot_ff} + CNT_W'(1);
   assign rd_addr   = (state_ff == ST_IDLE) ? req_data.led_index : slot_ff;
   assign time_sum  = {1'b0, rd_data.elapsed_time} + {1'b0, cmd_ff.step_ms};
   assign req_rgb   = '{red: cmd_ff.target_red, green: cmd_ff.target_green,
                        blue: cmd_ff.target_blue};

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      slot_in       = slot_ff;
      ent_in        = ent_ff;
      next_in       = next_ff;
      chan_in       = chan_ff;
      res_in        = res_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_data       = ent_ff;
      div_load      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in  = req_data;
               slot_in = req_data.led_index;
               unique case (req_data.opcode)
                  OP_DRIVE: begin
                     if ({1'b0, req_data.led_index} < slots) begin
                        state_in = ST_DRV_RD;
                     end
                  end
                  OP_STEP: begin
                     if (slots != '0) begin
                        slot_in  = '0;
                        state_in = ST_STP_ISSUE;
                     end
                  end
                  OP_QUERY: begin
                     if ({1'b0, req_data.led_index} < slots) begin
                        state_in = ST_QRY_RD;
                     end else begin
                        rsp_strobe_in = 1'b1;
                        rsp_data_in   = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DRV_RD: begin
            wr_en                 = 1'b1;
            wr_data.start_color   = rd_data.current_color;
            wr_data.target_color  = req_rgb;
            wr_data.current_color = (cmd_ff.fade_duration_ms == '0) ? req_rgb
                                                                    : rd_data.current_color;
            wr_data.elapsed_time  = '0;
            wr_data.duration_time = cmd_ff.fade_duration_ms;
            wr_data.fade_active   = (cmd_ff.fade_duration_ms != '0);
            state_in              = ST_IDLE;
         end
         ST_QRY_RD: begin
            rsp_strobe_in = 1'b1;
            rsp_data_in   = '{color_red:    rd_data.current_color.red,
                              color_green:  rd_data.current_color.green,
                              color_blue:   rd_data.current_color.blue,
                              fade_running: rd_data.fade_active};
            state_in      = ST_IDLE;
         end
         ST_STP_ISSUE: begin
            state_in = ST_STP_RD;
         end
         ST_STP_RD: begin
            ent_in = rd_data;
            if (!rd_data.fade_active || (rd_data.duration_time == '0)) begin
               wr_en                 = 1'b1;
               wr_data               = rd_data;
               wr_data.current_color = rd_data.target_color;
               wr_data.fade_active   = 1'b0;
               if (slot_nxt < slots) begin
                  slot_in  = slot_nxt[IDX_W-1:0];
                  state_in = ST_STP_ISSUE;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               if (time_sum >= {1'b0, rd_data.duration_time}) begin
                  next_in = rd_data.duration_time;
               end else begin
                  next_in = time_sum[TIME_W-1:0];
               end
               chan_in  = CH_RED;
               state_in = ST_STP_MUL;
            end
         end
         ST_STP_MUL: begin
            div_load = 1'b1;
            state_in = ST_STP_DIV;
         end
         ST_STP_DIV: begin
            if (div_done) begin
               unique case (chan_ff)
                  CH_RED:   res_in.red   = div_level;
                  CH_GREEN: res_in.green = div_level;
                  default:  res_in.blue  = div_level;
               endcase
               if (chan_ff == CH_BLUE) begin
                  state_in = ST_STP_WR;
               end else begin
                  chan_in  = chan_ff + 2'd1;
                  state_in = ST_STP_MUL;
               end
            end
         end
         ST_STP_WR: begin
            wr_en                 = 1'b1;
            wr_data               = ent_ff;
            wr_data.current_color = res_ff;
            wr_data.elapsed_time  = next_ff;
            wr_data.fade_active   = (next_ff != ent_ff.duration_time);
            if (slot_nxt < slots) begin
               slot_in  = slot_nxt[IDX_W-1:0];
               state_in = ST_STP_ISSUE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (csr_valid && csr_ready) begin
         count_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      slot_ff     <= slot_in;
      ent_ff      <= ent_in;
      next_ff     <= next_in;
      chan_ff     <= chan_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         count_ff      <= CNT_W'(NUM_LEDS);
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         count_ff      <= count_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_ready  = 1'b1;

endmodule
`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 100ps

import lcfe_pkg::*;

class fade_scoreboard;
   lcfe_rgb_type     start_rgb[NUM_LEDS];
   lcfe_rgb_type     target_rgb[NUM_LEDS];
   lcfe_rgb_type     current_rgb[NUM_LEDS];
   int unsigned      slot_elapsed[NUM_LEDS];
   int unsigned      slot_span[NUM_LEDS];
   bit               fading[NUM_LEDS];
   logic [CNT_W-1:0] slot_limit;
   lcfe_rsp_type     expected_colors[$];
   int unsigned      errors;

   function new();
      foreach (fading[i]) begin
         start_rgb[i]    = '0;
         target_rgb[i]   = '0;
         current_rgb[i]  = '0;
         slot_elapsed[i] = 0;
         slot_span[i]    = 0;
         fading[i]       = 1'b0;
      end
      slot_limit = CNT_W'(NUM_LEDS);
      errors     = 0;
   endfunction

   function int unsigned slots_in_use();
      return (slot_limit > NUM_LEDS) ? NUM_LEDS : int'(slot_limit);
   endfunction

   function int unsigned pending();
      return expected_colors.size();
   endfunction

   function void note_slot_limit(logic [CNT_W-1:0] count);
      slot_limit = count;
   endfunction

   // start + (target - start) * el / dur, truncated toward zero, clamped
   function logic [COLOR_W-1:0] fade_level(logic [COLOR_W-1:0] from,
                                           logic [COLOR_W-1:0] to,
                                           int unsigned el, int unsigned dur);
      longint span;
      longint lvl;
      span = longint'(to) - longint'(from);
      lvl  = longint'(from) + (span * longint'(el)) / longint'(dur);
      if (lvl < 0)
         lvl = 0;
      if (lvl > (1 << COLOR_W) - 1)
         lvl = (1 << COLOR_W) - 1;
      return lvl[COLOR_W-1:0];
   endfunction

   function void note_request(lcfe_req_type r);
      int unsigned  slots;
      int unsigned  idx;
      int unsigned  next_ms;
      lcfe_rsp_type exp_rsp;
      slots = slots_in_use();
      idx   = int'(r.led_index);
      case (r.opcode)
         OP_DRIVE: begin
            if (idx < slots) begin
               start_rgb[idx]    = current_rgb[idx];
               target_rgb[idx]   = {r.target_red, r.target_green, r.target_blue};
               slot_elapsed[idx] = 0;
               slot_span[idx]    = int'(r.fade_duration_ms);
               fading[idx]       = (r.fade_duration_ms != 0);
               if (!fading[idx])
                  current_rgb[idx] = target_rgb[idx];
            end
         end
         OP_STEP: begin
            for (int i = 0; i < slots; i++) begin
               if (!fading[i] || slot_span[i] == 0) begin
                  current_rgb[i] = target_rgb[i];
                  fading[i]      = 1'b0;
               end else begin
                  next_ms = slot_elapsed[i] + int'(r.step_ms);
                  if (next_ms >= slot_span[i]) begin
                     next_ms   = slot_span[i];
                     fading[i] = 1'b0;
                  end
                  current_rgb[i].red   = fade_level(start_rgb[i].red, target_rgb[i].red,
                                                    next_ms, slot_span[i]);
                  current_rgb[i].green = fade_level(start_rgb[i].green,
                                                    target_rgb[i].green,
                                                    next_ms, slot_span[i]);
                  current_rgb[i].blue  = fade_level(start_rgb[i].blue, target_rgb[i].blue,
                                                    next_ms, slot_span[i]);
                  slot_elapsed[i] = next_ms;
               end
            end
         end
         OP_QUERY: begin
            exp_rsp = '0;
            if (idx < slots) begin
               exp_rsp.color_red    = current_rgb[idx].red;
               exp_rsp.color_green  = current_rgb[idx].green;
               exp_rsp.color_blue   = current_rgb[idx].blue;
               exp_rsp.fade_running = fading[idx];
            end
            expected_colors.push_back(exp_rsp);
         end
         OP_NOP: ;
      endcase
   endfunction

   task report_mismatch(string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
   endtask

   task check_result(lcfe_rsp_type got);
      lcfe_rsp_type want;
      if (expected_colors.size() == 0) begin
         report_mismatch($sformatf("query result %h with no request pending", got));
         return;
      end
      want = expected_colors.pop_front();
      if (got.color_red !== want.color_red)
         report_mismatch($sformatf("red %h, want %h", got.color_red, want.color_red));
      if (got.color_green !== want.color_green)
         report_mismatch($sformatf("green %h, want %h", got.color_green,
                                   want.color_green));
      if (got.color_blue !== want.color_blue)
         report_mismatch($sformatf("blue %h, want %h", got.color_blue, want.color_blue));
      if (got.fade_running !== want.fade_running)
         report_mismatch($sformatf("fade_running %b, want %b", got.fade_running,
                                   want.fade_running));
   endtask
endclass

module tb_top;
   localparam int STALL_LIMIT     = 40000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int ITEMS_PER_PHASE = 15;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             start     = 1'b0;
   logic             busy;
   lcfe_req_type     req_data  = '0;
   logic             rsp_strobe;
   lcfe_rsp_type     rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CNT_W-1:0] csr_data  = '0;

   int               quiet_cycles  = 0;
   bit               back_to_back  = 1'b0;
   fade_scoreboard   fade_sb       = new();

   always #6 clock = ~clock;

   led_color_fade_engine_unit dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_strobe)
            fade_sb.check_result(rsp_data);
         if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < STALL_LIMIT)
         @(posedge clock);
      $display("tb_top NOT OK");
      $finish;
   end

   function automatic lcfe_req_type fade_request(logic [1:0] op, logic [7:0] idx,
                                                 logic [23:0] rgb, logic [15:0] dur,
                                                 logic [15:0] step);
      lcfe_req_type r;
      r.opcode           = op;
      r.led_index        = idx;
      r.target_red       = rgb[23:16];
      r.target_green     = rgb[15:8];
      r.target_blue      = rgb[7:0];
      r.fade_duration_ms = dur;
      r.step_ms          = step;
      return r;
   endfunction

   // hot slots get drive and query traffic so fades are seen mid-way
   function automatic lcfe_req_type random_request();
      lcfe_req_type r;
      int unsigned  slots;
      int unsigned  pick;
      slots = fade_sb.slots_in_use();
      pick  = $urandom_range(0, 99);
      if (pick < 35)
         r.opcode = OP_DRIVE;
      else if (pick < 60)
         r.opcode = OP_STEP;
      else if (pick < 95)
         r.opcode = OP_QUERY;
      else
         r.opcode = OP_NOP;
      pick = $urandom_range(0, 99);
      if (slots == 0 || pick < 15)
         r.led_index = IDX_W'($urandom_range(0, 255));
      else if (pick < 60)
         r.led_index = IDX_W'($urandom_range(0, ((slots < 8) ? slots : 8) - 1));
      else
         r.led_index = IDX_W'($urandom_range(0, slots - 1));
      r.target_red   = COLOR_W'($urandom_range(0, 255));
      r.target_green = COLOR_W'($urandom_range(0, 255));
      r.target_blue  = COLOR_W'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
         0:       r.fade_duration_ms = '0;
         1:       r.fade_duration_ms = '1;
         2, 3:    r.fade_duration_ms = TIME_W'($urandom_range(0, 65535));
         default: r.fade_duration_ms = TIME_W'($urandom_range(1, 200));
      endcase
      case ($urandom_range(0, 9))
         0:       r.step_ms = '0;
         1:       r.step_ms = '1;
         2:       r.step_ms = TIME_W'($urandom_range(0, 65535));
         default: r.step_ms = TIME_W'($urandom_range(1, 60));
      endcase
      return r;
   endfunction

   task automatic send_request(input lcfe_req_type r, input bit hold_for_results);
      int unsigned gap;
      gap = back_to_back ? 0 : $urandom_range(0, 10);
      if (hold_for_results || gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
         do @(posedge clock); while (hold_for_results && fade_sb.pending() != 0);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      fade_sb.note_request(r);
   endtask

   task automatic write_slot_limit(input logic [CNT_W-1:0] count);
      start <= 1'b0;
      do @(posedge clock); while (fade_sb.pending() != 0 || busy);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= count;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      fade_sb.note_slot_limit(count);
   endtask

   initial begin
      logic [CNT_W-1:0] phase_counts[8];
      phase_counts = '{9'd256, 9'd1, 9'd6, 9'd0, 9'd511, 9'd300, 9'd37, 9'd256};
      phase_counts[6] = CNT_W'($urandom_range(2, 256));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_request(fade_request(OP_QUERY, 8'd0, 24'h000000, 16'h0000, 16'h0000), 1'b0);
      send_request(fade_request(OP_QUERY, 8'd255, 24'h000000, 16'h0000, 16'h0000), 1'b0);
      // zero duration snaps to target
      send_request(fade_request(OP_DRIVE, 8'd0, 24'hFFFFFF, 16'h0000, 16'h0000), 1'b0);
      send_request(fade_request(OP_QUERY, 8'd0, 24'h000000, 16'h0000, 16'h0000), 1'b0);
      send_request(fade_request(OP_DRIVE, 8'd255, 24'hFF0080, 16'hFFFF, 16'h0000), 1'b0);
      send_request(fade_request(OP_QUERY, 8'd255, 24'h000000, 16'h0000, 16'h0000), 1'b0);
      send_request(fade_request(OP_STEP, 8'd0, 24'h000000, 16'h0000, 16'hFFFE), 1'b0);
      send_request(fade_request(OP_QUERY, 8'd255, 24'h000000, 16'h0000, 16'h0000), 1'b0);
      // falling fade, negative quotient truncates toward zero
      send_request(fade_request(OP_DRIVE, 8'd0, 24'h000000, 16'd7, 16'h0000), 1'b0);
      send_request(fade_request(OP_STEP, 8'd0, 24'h000000, 16'h0000, 16'd1), 1'b0);
      send_request(fade_request(OP_QUERY, 8'd0, 24'h000000, 16'h0000, 16'h0000), 1'b0);
      send_request(fade_request(OP_QUERY, 8'd255, 24'h000000, 16'h0000, 16'h0000), 1'b0);
      send_request(fade_request(OP_STEP, 8'd0, 24'h000000, 16'h0000, 16'h0000), 1'b0);
      send_request(fade_request(OP_QUERY, 8'd0, 24'h000000, 16'h0000, 16'h0000), 1'b0);
      send_request(fade_request(OP_NOP, 8'd255, 24'hFFFFFF, 16'hFFFF, 16'hFFFF), 1'b0);
      send_request(fade_request(OP_STEP, 8'd0, 24'h000000, 16'h0000, 16'hFFFF), 1'b0);
      send_request(fade_request(OP_QUERY, 8'd0, 24'h000000, 16'h0000, 16'h0000), 1'b0);

      write_slot_limit(9'd1);
      send_request(fade_request(OP_DRIVE, 8'd1, 24'h123456, 16'h0000, 16'h0000), 1'b0);
      send_request(fade_request(OP_QUERY, 8'd1, 24'h000000, 16'h0000, 16'h0000), 1'b0);
      send_request(fade_request(OP_QUERY, 8'd0, 24'h000000, 16'h0000, 16'h0000), 1'b0);

      write_slot_limit(9'd0);
      send_request(fade_request(OP_DRIVE, 8'd0, 24'hA5A5A5, 16'h0000, 16'h0000), 1'b0);
      send_request(fade_request(OP_STEP, 8'd0, 24'h000000, 16'h0000, 16'd100), 1'b0);
      send_request(fade_request(OP_QUERY, 8'd0, 24'h000000, 16'h0000, 16'h0000), 1'b0);

      write_slot_limit(9'd511);
      send_request(fade_request(OP_QUERY, 8'd255, 24'h000000, 16'h0000, 16'h0000), 1'b0);

      foreach (phase_counts[p]) begin
         write_slot_limit(phase_counts[p]);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(0, 7) == 0)
               back_to_back = !back_to_back;
            send_request(random_request(), $urandom_range(0, 19) == 0);
         end
      end

      start <= 1'b0;
      do @(posedge clock); while (fade_sb.pending() != 0 || busy);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fade_sb.errors == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end
endmodule

### led_color_fade_engine_unit.f
hw/rtl/lcfe_pkg.sv
hw/rtl/lcfe_slot_ram.sv
hw/rtl/lcfe_blend_unit.sv
hw/rtl/led_color_fade_engine_unit.sv
bench/tb_top.sv
